/* rtl/matrix3_inverse_defines.svh */
// Assertion macros for the 3x3 matrix inverse block.
`ifndef MATRIX3_INVERSE_DEFINES_SVH
`define MATRIX3_INVERSE_DEFINES_SVH
`ifndef SYNTHESIS
`define M3I_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m3i check failed");
`define M3I_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m3i check failed");
`else
`define M3I_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define M3I_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/m3i_pkg.sv */
// Shared types and constants for the 3x3 matrix inverse block.
package m3i_pkg;
    localparam int EntryW = 32;
    localparam int CofW   = 65;
    localparam int DetW   = 98;
    localparam int NumW   = 97;
    localparam int QuoW   = 97;
    localparam int DivSteps = QuoW;

    typedef logic signed [EntryW-1:0] entry_t;
    typedef logic signed [CofW-1:0]   cof_t;
    typedef logic signed [DetW-1:0]   det_t;

    typedef struct packed {
        entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } mat_t;

    // front-to-back queue entry: cofactors, determinant
    typedef struct packed {
        cof_t [8:0] cof;  // index = row*3+col of cofactor matrix
        det_t       det;
    } cls_t;

    typedef struct packed {
        entry_t [8:0] inv;
        entry_t       det_value;
        logic         singular;
    } res_t;

    function automatic entry_t sat_round(input logic [QuoW:0] mag, input logic neg);
        logic [QuoW:0] lim;
        lim = neg ? (QuoW+1)'(33'h080000000) : (QuoW+1)'(33'h07FFFFFFF);
        if (mag > lim)
            mag = lim;
        return neg ? entry_t'(-mag[EntryW-1:0]) : entry_t'(mag[EntryW-1:0]);
    endfunction
endpackage

/* rtl/matrix3_inverse.sv */
// Top level of the 3x3 matrix inverse block.
//
//  channel | dir | handshake               | payload
//  s_axis  | in  | s_axis_tvalid/tready    | tdata: m00..m22, 32 b each
//  m_axis  | out | m_axis_tvalid/tready    | tdata: inv00..inv22, det_value; tuser: singular
//
// One item per cycle sustained while m_axis does not stall. An item passes 104
// registers: 5 in the cofactor/determinant front, 1 in the queue, then a load
// stage and 97 one-bit divider stages in the back. Reset clears valid bits,
// queue count and pointers. A stall on m_axis holds the back pipeline; the
// two-entry queue lets the front keep filling, and s_axis_tready drops once the
// queue is full and the front's last stage holds an item.
`include "matrix3_inverse_defines.svh"
module matrix3_inverse
    import m3i_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,  // m00,m01,m02,m10,m11,m12,m20,m21,m22
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [319:0] m_axis_tdata,  // inv00..inv22, det_value
    output logic         m_axis_tuser   // singular
);
    mat_t mat;
    cls_t f_cls, q_cls;
    res_t res;
    logic f_valid, f_ready, q_valid, q_ready;

    assign mat = '{m00: s_axis_tdata[31:0],    m01: s_axis_tdata[63:32],
                   m02: s_axis_tdata[95:64],   m10: s_axis_tdata[127:96],
                   m11: s_axis_tdata[159:128], m12: s_axis_tdata[191:160],
                   m20: s_axis_tdata[223:192], m21: s_axis_tdata[255:224],
                   m22: s_axis_tdata[287:256]};

    m3i_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_mat(mat),
        .out_valid(f_valid), .out_ready(f_ready), .out_cls(f_cls)
    );

    m3i_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_cls),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_cls)
    );

    m3i_back u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_cls(q_cls),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    always_comb
    begin
        for (int k = 0; k < 9; k++)
            m_axis_tdata[32*k +: 32] = res.inv[k];
        m_axis_tdata[319:288] = res.det_value;
        m_axis_tuser = res.singular;
    end

    // singular results carry zero data
    `M3I_ASSERT_IMPL(a_sing_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser,
                     m_axis_tdata == '0)
    // a stalled result holds
    `M3I_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))
endmodule

/* rtl/m3i_front.sv */
// Front: cofactor and determinant pipeline, one matrix per cycle unless out_ready stalls it.
module m3i_front
    import m3i_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  mat_t in_mat,
    output logic out_valid,
    input  logic out_ready,
    output cls_t out_cls
);
    // stage 1: products; stage 2: cofactors; stage 3: column products split into
    // low/high cofactor halves; stage 4: column products; stage 5: det sum
    logic [4:0] vld_reg;
    logic signed [63:0] prod_reg [18];
    entry_t col0_s1_reg [3];
    entry_t col0_s2_reg [3];
    cof_t cof_s2_reg [9];
    cof_t cof_s3_reg [9];
    cof_t cof_s4_reg [9];
    cof_t cof_s5_reg [9];
    logic signed [65:0] plo_reg [3];
    logic signed [65:0] phi_reg [3];
    det_t dprod_reg [3];
    det_t det_reg;
    logic adv;
    entry_t m [9];

    assign adv = !vld_reg[4] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[4];

    assign m = '{in_mat.m00, in_mat.m01, in_mat.m02, in_mat.m10, in_mat.m11,
                 in_mat.m12, in_mat.m20, in_mat.m21, in_mat.m22};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[2*(i*3+j)]   <= 64'(m[((i+1)%3)*3+(j+1)%3])
                                           * 64'(m[((i+2)%3)*3+(j+2)%3]);
                    prod_reg[2*(i*3+j)+1] <= 64'(m[((i+2)%3)*3+(j+1)%3])
                                           * 64'(m[((i+1)%3)*3+(j+2)%3]);
                end
                col0_s1_reg[i] <= m[i*3];
            end
            for (int k = 0; k < 9; k++)
            begin
                cof_s2_reg[k] <= CofW'(prod_reg[2*k]) - CofW'(prod_reg[2*k+1]);
                cof_s3_reg[k] <= cof_s2_reg[k];
                cof_s4_reg[k] <= cof_s3_reg[k];
                cof_s5_reg[k] <= cof_s4_reg[k];
            end
            for (int i = 0; i < 3; i++)
            begin
                col0_s2_reg[i] <= col0_s1_reg[i];
                // 32x33 partial products: unsigned low half and signed high half
                plo_reg[i] <= col0_s2_reg[i] * $signed({1'b0, cof_s2_reg[i*3][31:0]});
                phi_reg[i] <= col0_s2_reg[i] * $signed(cof_s2_reg[i*3][CofW-1:32]);
                dprod_reg[i] <= (DetW'(phi_reg[i]) <<< 32) + DetW'(plo_reg[i]);
            end
            det_reg <= dprod_reg[0] + dprod_reg[1] + dprod_reg[2];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
            out_cls.cof[k] = cof_s5_reg[k];
        out_cls.det = det_reg;
    end
endmodule

/* rtl/m3i_queue.sv */
// Two-entry queue between front and back.
module m3i_queue
    import m3i_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cls_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output cls_t out_data
);
    cls_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic wp_reg, rp_reg;
    logic wr, rd;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;
    assign out_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= in_data;
    end
endmodule

/* rtl/m3i_back.sv */
// Back: pipelined restoring divider, one quotient bit per stage, per entry.
module m3i_back
    import m3i_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cls_t in_cls,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);
    localparam int N = DivSteps;
    localparam int RemW = DetW + 1;

    logic [N:0] vld_reg;
    logic [NumW-1:0] num_reg [N+1][9];
    logic [RemW-1:0] rem_reg [N+1][9];
    logic [8:0] neg_reg [N+1];
    logic [DetW-1:0] den_reg [N+1];
    entry_t detv_reg [N+1];
    logic sing_reg [N+1];
    logic adv;
    logic dneg;
    logic [DetW-1:0] dmag;
    logic [DetW-1:0] dq;

    assign adv = !vld_reg[N] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[N];

    always_comb
    begin
        dneg = in_cls.det[DetW-1];
        dmag = dneg ? DetW'(-in_cls.det) : DetW'(in_cls.det);
        dq = (dmag >> 32) + DetW'(dmag[31]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[N-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
            begin
                num_reg[0][k] <= {(in_cls.cof[k][CofW-1] ? CofW'(-in_cls.cof[k])
                                  : CofW'(in_cls.cof[k])), 32'd0};
                rem_reg[0][k] <= '0;
                neg_reg[0][k] <= in_cls.cof[k][CofW-1] ^ dneg;
            end
            den_reg[0] <= dmag;
            detv_reg[0] <= sat_round((QuoW+1)'(dq), dneg);
            sing_reg[0] <= in_cls.det == '0;
            for (int s = 0; s < N; s++)
            begin
                for (int k = 0; k < 9; k++)
                begin
                    logic [RemW-1:0] t;
                    logic ge;
                    t = {rem_reg[s][k][RemW-2:0], num_reg[s][k][NumW-1]};
                    ge = t >= RemW'(den_reg[s]);
                    rem_reg[s+1][k] <= ge ? t - RemW'(den_reg[s]) : t;
                    num_reg[s+1][k] <= {num_reg[s][k][NumW-2:0], ge};
                end
                neg_reg[s+1] <= neg_reg[s];
                den_reg[s+1] <= den_reg[s];
                detv_reg[s+1] <= detv_reg[s];
                sing_reg[s+1] <= sing_reg[s];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            logic [QuoW:0] q;
            logic up;
            up = {rem_reg[N][k], 1'b0} >= {1'b0, RemW'(den_reg[N])};
            q = (QuoW+1)'(num_reg[N][k]) + (QuoW+1)'(up);
            out_res.inv[(k%3)*3 + k/3] = sing_reg[N] ? '0 : sat_round(q, neg_reg[N][k]);
        end
        out_res.det_value = sing_reg[N] ? '0 : detv_reg[N];
        out_res.singular = sing_reg[N];
    end
endmodule
